// ===== src/lzss_pkg.sv =====
// Shared constants, FSM state type and controller/datapath bundles
// for the LZSS ring decompressor. No dependencies.
package lzss_pkg;

    localparam int RING_SIZE = 4096;
    localparam int LOOKAHEAD = 18;
    localparam int RING_AW = $clog2(RING_SIZE);
    localparam logic [RING_AW-1:0] RING_START = RING_AW'(RING_SIZE - LOOKAHEAD);
    localparam int MIN_MATCH = 3;
    localparam int LEN_W = $clog2(LOOKAHEAD + 1);
    localparam logic [15:0] MAX_OUTPUT_RESET = 16'd16384;
    localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

    typedef enum logic [8:0] {
        ST_HDR_HI = 9'b000000001,
        ST_HDR_LO = 9'b000000010,
        ST_FLAG   = 9'b000000100,
        ST_LIT    = 9'b000001000,
        ST_MHI    = 9'b000010000,
        ST_MLO    = 9'b000100000,
        ST_IDLE   = 9'b001000000,
        ST_READ   = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic start;
        logic load_body;
        logic load_flags;
        logic hold;
        logic load_copy;
        logic rd_issue;
        logic emit_lit;
        logic emit_copy;
        logic emit_err;
        logic fin1;
        logic fin2;
        logic last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic ovf;
        logic in_msb;
        logic flag_next_msb;
        logic flags_le1;
        logic body_le1;
        logic body_le2;
        logic len_last;
    } ctrl_status_t;

endpackage

// ===== src/lzss_in_if.sv =====
// Compressed byte request channel: valid/ready plus in_byte and first.
// No dependencies.
interface lzss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first;

    modport source (output valid, output in_byte, output first, input ready);
    modport sink (input valid, input in_byte, input first, output ready);
endinterface

// ===== src/lzss_out_if.sv =====
// Decompressed result request channel: valid/ready plus result fields.
// No dependencies.
interface lzss_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [15:0] out_count;
    logic        last_of_run;
    logic        end_of_stream;
    logic        overflow_error;

    modport source (
        output valid, output out_byte, output out_count, output last_of_run,
        output end_of_stream, output overflow_error, input ready
    );
    modport sink (
        input valid, input out_byte, input out_count, input last_of_run,
        input end_of_stream, input overflow_error, output ready
    );
endinterface

// ===== src/lzss_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/lzss_ctrl.sv =====
// Parse and copy sequencer for the LZSS decompressor.
// Depends on lzss_pkg (state type, command and status bundles).
module lzss_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_first,
    output logic                  in_ready,
    input  lzss_pkg::ctrl_status_t st,
    output lzss_pkg::ctrl_cmd_t    cmd
);
    import lzss_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   in_state;
    logic   fire;

    function automatic state_t after_token(input logic body_zero, input logic flags_zero,
                                           input logic next_lit);
        state_t s;
        if (body_zero)
        begin
            s = ST_IDLE;
        end
        else if (flags_zero)
        begin
            s = ST_FLAG;
        end
        else
        begin
            s = next_lit ? ST_LIT : ST_MHI;
        end
        return s;
    endfunction

    assign in_state = (state_reg != ST_READ) && (state_reg != ST_EMIT);
    assign in_ready = in_state && st.slot_free;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.slot_free)
                begin
                    if (st.ovf)
                    begin
                        cmd.emit_err = 1'b1;
                        cmd.last     = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_copy = 1'b1;
                        if (st.len_last)
                        begin
                            cmd.fin2   = 1'b1;
                            cmd.last   = 1'b1;
                            state_next = after_token(st.body_le2, st.flags_le1,
                                                     st.flag_next_msb);
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            default:
            begin
                if (fire)
                begin
                    if (in_first || state_reg == ST_HDR_HI)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_HDR_LO;
                    end
                    else
                    begin
                        case (state_reg)
                            ST_HDR_LO:
                            begin
                                cmd.load_body = 1'b1;
                                state_next    = ST_FLAG;
                            end
                            ST_FLAG:
                            begin
                                cmd.load_flags = 1'b1;
                                state_next     = st.in_msb ? ST_LIT : ST_MHI;
                            end
                            ST_LIT:
                            begin
                                cmd.last = 1'b1;
                                if (st.ovf)
                                begin
                                    cmd.emit_err = 1'b1;
                                    state_next   = ST_IDLE;
                                end
                                else
                                begin
                                    cmd.emit_lit = 1'b1;
                                    cmd.fin1     = 1'b1;
                                    state_next   = after_token(st.body_le1, st.flags_le1,
                                                               st.flag_next_msb);
                                end
                            end
                            ST_MHI:
                            begin
                                cmd.hold   = 1'b1;
                                state_next = ST_MLO;
                            end
                            ST_MLO:
                            begin
                                cmd.load_copy = 1'b1;
                                state_next    = ST_READ;
                            end
                            default:
                            begin
                                state_next = state_reg;
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HDR_HI;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/lzss_datapath.sv =====
// Ring buffer, stream counters and output register of the decompressor.
// Depends on lzss_pkg, lzss_ram and lzss_out_if.
module lzss_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_wdata,
    input  logic [7:0]             in_byte,
    input  lzss_pkg::ctrl_cmd_t    cmd,
    output lzss_pkg::ctrl_status_t st,
    lzss_out_if.source             out_ch
);
    import lzss_pkg::*;

    logic [15:0]        max_output_reg, max_output_next;
    logic [RING_AW-1:0] wp_reg, wp_next;
    logic [15:0]        emitted_reg, emitted_next;
    logic [16:0]        body_reg, body_next;
    logic [3:0]         flags_left_reg, flags_left_next;
    logic [7:0]         flag_shift_reg, flag_shift_next;
    logic               out_valid_reg, out_valid_next;

    logic [7:0]         held_reg, held_next;
    logic [RING_AW-1:0] cp_reg, cp_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic [15:0]        out_count_reg, out_count_next;
    logic               out_last_reg, out_last_next;
    logic               out_eos_reg, out_eos_next;
    logic               out_err_reg, out_err_next;

    logic [RING_AW-1:0] cp_offset;
    logic [7:0]         ram_rdata;
    logic [7:0]         emit_byte;
    logic               emit_any;
    logic               body_zero_after;
    logic [15:0]        match_word;

    assign st.slot_free     = !out_valid_reg || out_ch.ready;
    assign st.ovf           = emitted_reg >= max_output_reg;
    assign st.in_msb        = in_byte[7];
    assign st.flag_next_msb = flag_shift_reg[6];
    assign st.flags_le1     = flags_left_reg <= 4'd1;
    assign st.body_le1      = body_reg <= 17'd1;
    assign st.body_le2      = body_reg <= 17'd2;
    assign st.len_last      = len_reg == LEN_W'(1);

    assign cp_offset       = cp_reg - RING_START;
    assign emit_any        = cmd.emit_lit || cmd.emit_copy;
    assign emit_byte       = cmd.emit_lit ? in_byte : (rd_valid_reg ? ram_rdata : 8'd0);
    assign body_zero_after = (cmd.fin1 && st.body_le1) || (cmd.fin2 && st.body_le2);
    assign match_word      = {held_reg, in_byte};

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (RING_SIZE)
    ) u_ring (
        .clk   (clk),
        .we    (emit_any),
        .waddr (wp_reg),
        .wdata (emit_byte),
        .re    (cmd.rd_issue),
        .raddr (cp_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        max_output_next = cfg_we ? cfg_wdata : max_output_reg;
        wp_next         = wp_reg;
        emitted_next    = emitted_reg;
        body_next       = body_reg;
        flags_left_next = flags_left_reg;
        flag_shift_next = flag_shift_reg;
        held_next       = held_reg;
        cp_next         = cp_reg;
        len_next        = len_reg;
        rd_valid_next   = rd_valid_reg;
        out_byte_next   = out_byte_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        out_eos_next    = out_eos_reg;
        out_err_next    = out_err_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;

        if (cmd.start)
        begin
            wp_next         = RING_START;
            emitted_next    = '0;
            body_next       = '0;
            flags_left_next = '0;
            flag_shift_next = '0;
            held_next       = in_byte;
        end
        if (cmd.load_body)
        begin
            body_next = {1'b0, held_reg, in_byte} + 17'd1;
        end
        if (cmd.load_flags)
        begin
            body_next       = st.body_le1 ? 17'd0 : body_reg - 17'd1;
            flag_shift_next = in_byte;
            flags_left_next = FLAGS_PER_BYTE;
        end
        if (cmd.hold)
        begin
            held_next = in_byte;
        end
        if (cmd.load_copy)
        begin
            cp_next  = match_word[15:4];
            len_next = LEN_W'(match_word[3:0]) + LEN_W'(MIN_MATCH);
        end
        if (cmd.rd_issue)
        begin
            cp_next       = cp_reg + 1'b1;
            rd_valid_next = (emitted_reg >= 16'(RING_SIZE))
                         || (16'(cp_offset) < emitted_reg);
        end
        if (emit_any)
        begin
            wp_next        = wp_reg + 1'b1;
            emitted_next   = emitted_reg + 16'd1;
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_count_next = emitted_reg + 16'd1;
            out_last_next  = cmd.last;
            out_eos_next   = body_zero_after;
            out_err_next   = 1'b0;
        end
        if (cmd.emit_copy)
        begin
            len_next = len_reg - 1'b1;
        end
        if (cmd.emit_err)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = 8'd0;
            out_count_next = emitted_reg;
            out_last_next  = 1'b1;
            out_eos_next   = 1'b0;
            out_err_next   = 1'b1;
        end
        if (cmd.fin1 || cmd.fin2)
        begin
            if (cmd.fin1)
            begin
                body_next = st.body_le1 ? 17'd0 : body_reg - 17'd1;
            end
            else
            begin
                body_next = st.body_le2 ? 17'd0 : body_reg - 17'd2;
            end
            flags_left_next = (flags_left_reg != 4'd0) ? flags_left_reg - 4'd1 : 4'd0;
            flag_shift_next = {flag_shift_reg[6:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_output_reg <= MAX_OUTPUT_RESET;
            wp_reg         <= RING_START;
            emitted_reg    <= '0;
            body_reg       <= '0;
            flags_left_reg <= '0;
            flag_shift_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            max_output_reg <= max_output_next;
            wp_reg         <= wp_next;
            emitted_reg    <= emitted_next;
            body_reg       <= body_next;
            flags_left_reg <= flags_left_next;
            flag_shift_reg <= flag_shift_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        cp_reg        <= cp_next;
        len_reg       <= len_next;
        rd_valid_reg  <= rd_valid_next;
        out_byte_reg  <= out_byte_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
        out_eos_reg   <= out_eos_next;
        out_err_reg   <= out_err_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.out_byte       = out_byte_reg;
    assign out_ch.out_count      = out_count_reg;
    assign out_ch.last_of_run    = out_last_reg;
    assign out_ch.end_of_stream  = out_eos_reg;
    assign out_ch.overflow_error = out_err_reg;

endmodule

// ===== src/lzss_ring_decompressor_top.sv =====
// LZSS decompressor with a 4096-byte ring: sequencer plus datapath.
// Depends on lzss_pkg, lzss_in_if, lzss_out_if, lzss_ctrl, lzss_datapath.
//
// stream: one compressed byte per request; first marks the header high byte
//   of a new stream. result: one decompressed byte per request, or an error
//   request when max_output is reached.
// cfg_we/cfg_wdata write max_output (reset 16384); write only while idle.
// Header, flag and match-high bytes give no result.
// A literal's result is in the output register the next cycle. In a match,
// each copied byte is a registered ring read (READ) followed by an EMIT step
// that writes the ring and loads the output register; stream ready stays low
// until the last byte of the copy is emitted.
// Reset clears the sequencer and counters; the ring is not swept. Entries
// not yet written in the current stream are masked to zero by comparing
// their distance from the start pointer with the byte count.
// When the receiver stalls, the output register holds its result, stream
// ready drops and any copy in progress waits; nothing is lost.
module lzss_ring_decompressor_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    lzss_in_if.sink     stream,
    lzss_out_if.source  result
);
    import lzss_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t st;
    logic         in_ready;

    assign stream.ready = in_ready;

    lzss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_first (stream.first),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    lzss_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_byte   (stream.in_byte),
        .cmd       (cmd),
        .st        (st),
        .out_ch    (result)
    );

endmodule

// ===== tb/lzss_ring_decompressor_top_tb.sv =====
// Testbench for lzss_ring_decompressor_top: directed and random compressed streams,
// checked against a byte-level LZSS decoder kept in the bench.
// Depends on lzss_pkg, lzss_in_if, lzss_out_if and the top module.
module lzss_ring_decompressor_top_tb;
    import lzss_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] count;
        logic        last;
        logic        eos;
        logic        err;
    } out_rec_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    lzss_in_if  stream();
    lzss_out_if result();

    lzss_ring_decompressor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stream    (stream),
        .result    (result)
    );

    // decoder state
    logic [7:0]  ring_mem [RING_SIZE];
    bit          ring_set [RING_SIZE];
    logic [11:0] wptr;
    state_t      phase;
    logic [7:0]  flag_bits;
    int          flags_left;
    int          body_left;
    logic [7:0]  held;
    logic [15:0] emitted;
    logic [15:0] max_out;

    out_rec_t expected_out[$];
    int       errors;
    int       consumed;
    int       idle_in;
    int       idle_out;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function void clear_stream();
        for (int i = 0; i < RING_SIZE; i++)
            ring_set[i] = 1'b0;
        wptr = RING_START;
        flag_bits = '0;
        flags_left = 0;
        body_left = 0;
        held = '0;
        emitted = '0;
    endfunction

    function void body_dec(input int n);
        body_left = (body_left > n) ? body_left - n : 0;
    endfunction

    function bit emit_byte(input logic [7:0] v);
        if (emitted >= max_out) begin
            expected_out.push_back('{data: 8'h00, count: emitted, last: 1'b0, eos: 1'b0,
                                     err: 1'b1});
            phase = ST_IDLE;
            return 1'b0;
        end
        ring_mem[wptr] = v;
        ring_set[wptr] = 1'b1;
        wptr = wptr + 12'd1;
        emitted = emitted + 16'd1;
        expected_out.push_back('{data: v, count: emitted, last: 1'b0, eos: 1'b0, err: 1'b0});
        return 1'b1;
    endfunction

    function bit finish_token(input int n);
        body_dec(n);
        if (flags_left > 0)
            flags_left--;
        flag_bits = flag_bits << 1;
        if (body_left == 0) begin
            phase = ST_IDLE;
            return 1'b1;
        end
        if (flags_left == 0)
            phase = ST_FLAG;
        else
            phase = flag_bits[7] ? ST_LIT : ST_MHI;
        return 1'b0;
    endfunction

    function void decode_byte(input logic [7:0] b, input logic f);
        int          k;
        bit          ok;
        bit          done;
        logic [15:0] word;
        int          len;
        logic [11:0] cp;
        logic [7:0]  v;
        k = 0;
        done = 1'b0;
        if (f || phase == ST_HDR_HI) begin
            clear_stream();
            held = b;
            phase = ST_HDR_LO;
            consumed++;
            return;
        end
        if (phase != ST_IDLE)
            consumed++;
        case (phase)
            ST_HDR_LO: begin
                body_left = int'({held, b}) + 1;
                phase = ST_FLAG;
            end
            ST_FLAG: begin
                body_dec(1);
                flag_bits = b;
                flags_left = 8;
                phase = flag_bits[7] ? ST_LIT : ST_MHI;
            end
            ST_LIT: begin
                k = 1;
                if (emit_byte(b))
                    done = finish_token(1);
            end
            ST_MHI: begin
                held = b;
                phase = ST_MLO;
            end
            ST_MLO: begin
                word = {held, b};
                len = int'(word[3:0]) + MIN_MATCH;
                cp = word[15:4];
                ok = 1'b1;
                for (int i = 0; i < len && ok; i++) begin
                    v = ring_set[cp] ? ring_mem[cp] : 8'h00;
                    ok = emit_byte(v);
                    k++;
                    cp = cp + 12'd1;
                end
                if (ok)
                    done = finish_token(2);
            end
            default: ;
        endcase
        if (k > 0) begin
            expected_out[expected_out.size() - 1].last = 1'b1;
            if (done)
                expected_out[expected_out.size() - 1].eos = 1'b1;
        end
    endfunction

    function void check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        out_rec_t want;
        if (rst_n && result.valid && result.ready) begin
            if (expected_out.size() == 0) begin
                errors++;
                $display("%0t: unexpected request byte %0h count %0h", $time,
                         result.out_byte, result.out_count);
            end else begin
                want = expected_out.pop_front();
                check_field("out_byte", 16'(want.data), 16'(result.out_byte));
                check_field("out_count", want.count, result.out_count);
                check_field("last_of_run", 16'(want.last), 16'(result.last_of_run));
                check_field("end_of_stream", 16'(want.eos), 16'(result.end_of_stream));
                check_field("overflow_error", 16'(want.err), 16'(result.overflow_error));
            end
        end
    end

    always @(negedge clk)
        result.ready = ($urandom_range(99) >= idle_out);

    task automatic send_byte(input logic [7:0] b, input logic f);
        while ($urandom_range(99) < idle_in) begin
            stream.valid = 1'b0;
            @(negedge clk);
        end
        stream.valid = 1'b1;
        stream.in_byte = b;
        stream.first = f;
        @(posedge clk);
        while (!stream.ready)
            @(posedge clk);
        decode_byte(b, f);
        @(negedge clk);
    endtask

    task automatic drain();
        stream.valid = 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        max_out = v;
    endtask

    // no first after reset; literals, overlapping copy, unwritten copy, ring wrap
    task automatic test_first_stream_after_reset();
        send_byte(8'h00, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'hD0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h77, 1'b0);
    endtask

    // zero header: flag byte empties the body, token still decoded
    task automatic test_short_body();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hE0, 1'b0);
    endtask

    // max header, abandoned inside a match word by the next first
    task automatic test_restart_mid_stream();
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
    endtask

    task automatic test_output_limit();
        write_limit(16'd1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'h11, 1'b0);
    endtask

    task automatic test_random_streams(input int n_items, input logic [15:0] limit);
        int          stop_at;
        int          groups;
        int          hdr;
        logic [7:0]  flag;
        logic [11:0] pos;
        logic [7:0]  body_q[$];
        write_limit(limit);
        stop_at = consumed + n_items;
        while (consumed < stop_at) begin
            body_q.delete();
            groups = $urandom_range(1, 2);
            for (int g = 0; g < groups; g++) begin
                flag = 8'($urandom);
                body_q.push_back(flag);
                for (int i = 7; i >= 0; i--) begin
                    if (flag[i]) begin
                        body_q.push_back(8'($urandom));
                    end else begin
                        case ($urandom_range(2))
                            0: pos = 12'(RING_START + $urandom_range(0, 17));
                            1: pos = 12'($urandom_range(0, 40));
                            default: pos = 12'($urandom);
                        endcase
                        body_q.push_back(pos[11:4]);
                        body_q.push_back({pos[3:0], 4'($urandom)});
                    end
                end
            end
            hdr = body_q.size() - 1;
            case ($urandom_range(9))
                0: hdr = $urandom_range(0, hdr);
                1: hdr = hdr + $urandom_range(1, 5);
                default: ;
            endcase
            send_byte(8'(hdr >> 8), 1'b1);
            send_byte(8'(hdr), 1'b0);
            foreach (body_q[i])
                send_byte(body_q[i], 1'b0);
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        stream.valid = 1'b0;
        stream.in_byte = '0;
        stream.first = 1'b0;
        result.ready = 1'b0;
        errors = 0;
        consumed = 0;
        idle_in = 18;
        idle_out = 18;
        max_out = MAX_OUTPUT_RESET;
        clear_stream();
        phase = ST_HDR_HI;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_first_stream_after_reset();
        test_short_body();
        test_restart_mid_stream();
        test_output_limit();

        idle_in = 0;
        idle_out = 0;
        test_random_streams(20, 16'hFFFF);
        idle_in = 18;
        idle_out = 18;
        test_random_streams(15, 16'd40);
        test_random_streams(15, MAX_OUTPUT_RESET);

        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/lzss_pkg.sv
src/lzss_in_if.sv
src/lzss_out_if.sv
src/lzss_ram.sv
src/lzss_ctrl.sv
src/lzss_datapath.sv
src/lzss_ring_decompressor_top.sv
tb/lzss_ring_decompressor_top_tb.sv
